// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst_n is low
`define REBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge
`define REBS_NEVER(label, cond, msg) \
    `REBS_ASSERT(label, !(cond), msg)

`endif

// ===== src/rebs_pkg.sv =====
package rebs_pkg;

    // Event stack geometry
    localparam int STACK_DEPTH = 8;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int PEND_W    = 4;

    // Reset values of the decoder state
    localparam logic [3:0] HIST_RESET = 4'd3;
    localparam logic       BTN_RESET  = 1'b1;

    typedef enum logic [1:0] {
        MODE_ENC  = 2'd0,
        MODE_BTN  = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_OK    = 2'd1,
        EV_RIGHT = 2'd2,
        EV_LEFT  = 2'd3
    } event_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       enc_a;
        logic       enc_b;
        logic       button_level;
    } item_t;

    typedef struct packed {
        event_t              event_code;
        logic [PEND_W-1:0]   pending_count;
        logic                dropped;
    } result_t;

    // Quadrature step from {previous A, previous B, A, B}
    function automatic logic signed [1:0] step_lookup(input logic [3:0] hist);
        logic signed [1:0] step;
        case (hist)
            4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default: step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

// ===== src/rebs_in_reg.sv =====
module rebs_in_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: enc_a, enc_b, button_level, zero fill
    input  logic [rebs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode
    input  logic [rebs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                            take,
    output logic                            item_valid,
    output rebs_pkg::item_t                 item
);
    import rebs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Slot is free when empty or being drained this cycle
    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode         <= s_axis_tuser[1:0];
            item_reg.enc_a        <= s_axis_tdata[0];
            item_reg.enc_b        <= s_axis_tdata[1];
            item_reg.button_level <= s_axis_tdata[2];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/rebs_core.sv =====
module rebs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  rebs_pkg::item_t   item,
    output logic              take,
    output logic              res_valid,
    input  logic              res_ready,
    output rebs_pkg::result_t result
);
    import rebs_pkg::*;

    // Decoder state
    logic [3:0]        hist_reg, hist_next;
    logic signed [2:0] sum_reg, sum_next;
    logic              btn_reg, btn_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    event_t            store_reg [STACK_DEPTH];

    // Result register
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg;

    logic              advance;
    logic [3:0]        hist_cand;
    logic signed [2:0] sum_cand;
    logic              full;
    logic              raise;
    event_t            raise_code;
    logic              push;
    logic              drop;
    event_t            pop_code;
    logic [CNT_W-1:0]  pop_cnt;
    logic [IDX_W-1:0]  pop_idx;
    logic [IDX_W-1:0]  push_idx;

    assign advance  = item_valid && (!out_valid_reg || res_ready);
    assign take     = advance;
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign pop_cnt  = cnt_reg - CNT_W'(1);
    assign pop_idx  = pop_cnt[IDX_W-1:0];
    assign push_idx = cnt_reg[IDX_W-1:0];

    // Encoder step and running sum
    assign hist_cand = {hist_reg[1:0], item.enc_a, item.enc_b};
    always_comb
    begin
        logic signed [1:0] step;
        step     = step_lookup(hist_cand);
        sum_cand = sum_reg + {step[1], step};
    end

    // Per-item update
    always_comb
    begin
        hist_next  = hist_reg;
        sum_next   = sum_reg;
        btn_next   = btn_reg;
        cnt_next   = cnt_reg;
        raise      = 1'b0;
        raise_code = EV_NONE;
        pop_code   = EV_NONE;
        case (mode_t'(item.mode))
            MODE_ENC:
            begin
                hist_next = hist_cand;
                if (sum_cand > 3'sd1)
                begin
                    raise      = 1'b1;
                    raise_code = EV_RIGHT;
                    sum_next   = 3'sd0;
                end
                else if (sum_cand < -3'sd1)
                begin
                    raise      = 1'b1;
                    raise_code = EV_LEFT;
                    sum_next   = 3'sd0;
                end
                else
                begin
                    sum_next = sum_cand;
                end
            end
            MODE_BTN:
            begin
                if (item.button_level != btn_reg)
                begin
                    btn_next = item.button_level;
                    if (!item.button_level)
                    begin
                        raise      = 1'b1;
                        raise_code = EV_OK;
                    end
                end
            end
            MODE_READ:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = pop_cnt;
                    pop_code = store_reg[pop_idx];
                end
            end
            default:
            begin
                // unused mode: state holds
            end
        endcase
        push = raise && !full;
        drop = raise && full;
        if (push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Output valid: set on a new result, cleared on a downstream transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= HIST_RESET;
            sum_reg       <= 3'sd0;
            btn_reg       <= BTN_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                hist_reg <= hist_next;
                sum_reg  <= sum_next;
                btn_reg  <= btn_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // Stack entries and result payload
    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            store_reg[push_idx] <= raise_code;
        end
        if (advance)
        begin
            result_reg.event_code    <= pop_code;
            result_reg.pending_count <= PEND_W'(cnt_next);
            result_reg.dropped       <= drop;
        end
    end

    assign res_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== src/rotary_encoder_button_event_stack_top.sv =====
// Quadrature encoder and push-button decoder feeding a LIFO event stack.
// Each input transfer carries a mode in tuser (encoder sample, button sample
// or read) and returns exactly one result transfer with the popped event
// (none, OK, RIGHT, LEFT), the number of events still stacked and a drop
// flag for an event lost to a full stack. Throughput is one item per clock
// while m_axis_tready is high: an input register and a result register
// bracket a single pass of logic, and each item passes through both before
// its result is presented. Backpressure on m_axis_tready reaches
// s_axis_tready in the same cycle; the input register keeps taking items
// while a result waits, as long as the result register frees up. Stack
// entries need no clearing after reset.
`include "assert_macros.svh"

module rotary_encoder_button_event_stack_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: [0] enc_a, [1] enc_b, [2] button_level, [7:3] zero
    input  logic [rebs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: [1:0] mode
    input  logic [rebs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: [1:0] event_code, [5:2] pending_count, [6] dropped, [7] zero
    output logic [rebs_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import rebs_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    take;
    result_t result;

    rebs_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    rebs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .result     (result)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = M_TDATA_W'({result.dropped, result.pending_count,
                                      result.event_code});

    // Checks
    `REBS_NEVER(a_count_range,
        m_axis_tvalid && (result.pending_count > PEND_W'(STACK_DEPTH)),
        "pending count beyond stack depth")
    `REBS_ASSERT(a_drop_full,
        (m_axis_tvalid && result.dropped) |-> (result.pending_count == PEND_W'(STACK_DEPTH)),
        "drop reported with room left in the stack")
    `REBS_NEVER(a_pop_no_drop,
        m_axis_tvalid && result.dropped && (result.event_code != EV_NONE),
        "read returned an event and a drop together")
    `REBS_ASSERT(a_stall_holds_item,
        (item_valid && m_axis_tvalid && !m_axis_tready) |=> item_valid,
        "input item lost while the result was stalled")

endmodule
